/* rtl/core/tlv_frame_deframer_core_assert.svh */
// assertion macros shared by the deframer rtl
`ifndef TLV_FRAME_DEFRAMER_CORE_ASSERT_SVH
`define TLV_FRAME_DEFRAMER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define TFD_ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("tfd assertion failed");
`define TFD_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tfd assertion failed");
`define TFD_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tfd assertion failed");
`else
`define TFD_ASSERT_ALWAYS(label, clk, rst, expr)
`define TFD_ASSERT_IMP(label, clk, rst, ante, cons)
`define TFD_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

/* rtl/core/tfd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_pkg
// types and constants shared by the tlv deframer modules
// ----------------------------------------------------------------------------
package tfd_pkg;

  // input operation codes
  localparam logic OP_DATA    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  // result status codes
  localparam logic [2:0] ST_HEADER   = 3'd0;
  localparam logic [2:0] ST_PAYLOAD  = 3'd1;
  localparam logic [2:0] ST_COMPLETE = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE = 3'd3;
  localparam logic [2:0] ST_TOO_LONG = 3'd4;
  localparam logic [2:0] ST_DROPPED  = 3'd5;
  localparam logic [2:0] ST_RESTART  = 3'd6;

  // configuration register indexes
  localparam logic [1:0] REG_MAX_LENGTH = 2'd0;
  localparam logic [1:0] REG_TYPE_A     = 2'd1;
  localparam logic [1:0] REG_TYPE_B     = 2'd2;
  localparam logic [1:0] REG_TYPE_C     = 2'd3;

  localparam logic [2:0] HDR_BYTES = 3'd6;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  typedef struct packed {
    logic       restart;
    logic [7:0] data;
  } tfd_item_t;

  typedef struct packed {
    logic [31:0] max_length;
    logic [7:0]  type_a;
    logic [7:0]  type_b;
    logic [7:0]  type_c;
  } tfd_cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [7:0]  frame_code;
    logic [7:0]  frame_flags;
    logic [31:0] frame_length;
    logic        last;
  } tfd_result_t;

endpackage

/* rtl/core/tfd_stream_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd stream interfaces
// valid/ready channels for incoming bytes and deframer results
// ----------------------------------------------------------------------------
interface tfd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface tfd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        payload_valid;
  logic [7:0]  payload_byte;
  logic [7:0]  frame_code;
  logic [7:0]  frame_flags;
  logic [31:0] frame_length;
  logic        last;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output frame_code, output frame_flags, output frame_length,
                  output last, input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input frame_code, input frame_flags, input frame_length,
                  input last, output ready);
endinterface

/* rtl/core/tlv_frame_deframer_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlv_frame_deframer_core
// byte-serial deframer for frames with a 6-byte type/flags/length header
// ----------------------------------------------------------------------------
// Takes one stream byte (or a restart) per clock and returns one result per
// item. Sustained rate is one item per cycle while neither side stalls: the
// back end updates header and payload state once per item. An item passes
// through the two-entry input queue, then the result register; both sides may
// stall independently. Registers are written through wr_en/wr_index/wr_data by
// the user only while the block is idle; the block does not enforce this.

module tlv_frame_deframer_core (
  input  logic        clk,
  input  logic        rst,
  tfd_in_if.sink      in,
  tfd_out_if.source   out,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [31:0] wr_data
);

  tfd_pkg::tfd_cfg_t  cfg;
  tfd_pkg::tfd_item_t q_item;
  logic               q_valid;
  logic               q_pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_length <= 32'd1048576;
      cfg.type_a     <= 8'd1;
      cfg.type_b     <= 8'd2;
      cfg.type_c     <= 8'd3;
    end else if (wr_en) begin
      unique case (wr_index)
        tfd_pkg::REG_MAX_LENGTH: cfg.max_length <= wr_data;
        tfd_pkg::REG_TYPE_A:     cfg.type_a     <= wr_data[7:0];
        tfd_pkg::REG_TYPE_B:     cfg.type_b     <= wr_data[7:0];
        tfd_pkg::REG_TYPE_C:     cfg.type_c     <= wr_data[7:0];
        default:                 cfg            <= cfg;
      endcase
    end
  end

  tfd_front u_front (
    .clk     (clk),
    .rst     (rst),
    .in      (in),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  tfd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .out     (out)
  );

endmodule

/* rtl/core/tfd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_front
// accepts stream items, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`include "tlv_frame_deframer_core_assert.svh"

module tfd_front (
  input  logic             clk,
  input  logic             rst,
  tfd_in_if.sink           in,
  output tfd_pkg::tfd_item_t q_item,
  output logic             q_valid,
  input  logic             q_pop
);

  tfd_pkg::tfd_item_t entry [tfd_pkg::QUEUE_DEPTH];
  logic [tfd_pkg::QPTR_W-1:0] wr_ptr;
  logic [tfd_pkg::QPTR_W-1:0] rd_ptr;
  logic [tfd_pkg::QPTR_W:0]   count;
  logic                       push;
  logic                       pop;
  tfd_pkg::tfd_item_t         new_item;

  assign in.ready = (count != (tfd_pkg::QPTR_W+1)'(tfd_pkg::QUEUE_DEPTH));
  assign push     = in.valid && in.ready;
  assign pop      = q_pop && q_valid;
  assign q_valid  = (count != '0);
  assign q_item   = entry[rd_ptr];

  // classify: restart drops the byte, data keeps it
  always_comb begin
    new_item.restart = (in.operation == tfd_pkg::OP_RESTART);
    new_item.data    = new_item.restart ? 8'd0 : in.data_byte;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= new_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `TFD_ASSERT_ALWAYS(a_count_bound, clk, rst, count <= (tfd_pkg::QPTR_W+1)'(tfd_pkg::QUEUE_DEPTH))
  `TFD_ASSERT_NXT(a_count_up, clk, rst, push && !pop, count == $past(count) + 1'b1)
  `TFD_ASSERT_NXT(a_count_down, clk, rst, pop && !push, count == $past(count) - 1'b1)

endmodule

/* rtl/core/tfd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tfd_back
// header assembly, frame checks, payload counting and the result register
// ----------------------------------------------------------------------------
`include "tlv_frame_deframer_core_assert.svh"

module tfd_back (
  input  logic               clk,
  input  logic               rst,
  input  tfd_pkg::tfd_cfg_t  cfg,
  input  tfd_pkg::tfd_item_t q_item,
  input  logic               q_valid,
  output logic               q_pop,
  tfd_out_if.source          out
);

  logic [2:0]  header_count;
  logic [7:0]  type_hold;
  logic [7:0]  flags_hold;
  logic [31:0] length_hold;
  logic [31:0] payload_count;
  logic        error_hold;

  logic [2:0]  header_count_next;
  logic [7:0]  type_hold_next;
  logic [7:0]  flags_hold_next;
  logic [31:0] length_hold_next;
  logic [31:0] payload_count_next;
  logic        error_hold_next;
  logic [31:0] payload_inc;
  logic        type_ok;

  tfd_pkg::tfd_result_t res;
  tfd_pkg::tfd_result_t out_reg;
  logic                 out_valid;

  assign q_pop = q_valid && (!out_valid || out.ready);

  assign payload_inc = payload_count + 32'd1;

  always_comb begin
    header_count_next  = header_count;
    type_hold_next     = type_hold;
    flags_hold_next    = flags_hold;
    length_hold_next   = length_hold;
    payload_count_next = payload_count;
    error_hold_next    = error_hold;
    res                = '0;
    type_ok            = 1'b0;

    if (q_item.restart) begin
      header_count_next  = '0;
      type_hold_next     = '0;
      flags_hold_next    = '0;
      length_hold_next   = '0;
      payload_count_next = '0;
      error_hold_next    = 1'b0;
      res.status         = tfd_pkg::ST_RESTART;
    end else if (error_hold) begin
      res.status       = tfd_pkg::ST_DROPPED;
      res.frame_code   = type_hold;
      res.frame_flags  = flags_hold;
      res.frame_length = length_hold;
    end else if (header_count != tfd_pkg::HDR_BYTES) begin
      case (header_count)
        3'd0: begin
          type_hold_next     = q_item.data;
          flags_hold_next    = '0;
          length_hold_next   = '0;
          payload_count_next = '0;
        end
        3'd1: begin
          flags_hold_next = q_item.data;
        end
        default: begin
          length_hold_next = {length_hold[23:0], q_item.data};
        end
      endcase
      header_count_next = header_count + 3'd1;
      res.status        = tfd_pkg::ST_HEADER;
      if (header_count_next == tfd_pkg::HDR_BYTES) begin
        res.frame_code   = type_hold_next;
        res.frame_flags  = flags_hold_next;
        res.frame_length = length_hold_next;
        type_ok = (type_hold_next == cfg.type_a) || (type_hold_next == cfg.type_b) ||
                  (type_hold_next == cfg.type_c);
        if (!type_ok) begin
          error_hold_next = 1'b1;
          res.status      = tfd_pkg::ST_BAD_TYPE;
        end else if (length_hold_next > cfg.max_length) begin
          error_hold_next = 1'b1;
          res.status      = tfd_pkg::ST_TOO_LONG;
        end else if (length_hold_next == 32'd0) begin
          // empty frame completes on its last header byte
          header_count_next = '0;
          res.status        = tfd_pkg::ST_COMPLETE;
          res.last          = 1'b1;
        end
      end
    end else begin
      payload_count_next = payload_inc;
      res.payload_valid  = 1'b1;
      res.payload_byte   = q_item.data;
      res.frame_code     = type_hold;
      res.frame_flags    = flags_hold;
      res.frame_length   = length_hold;
      if (payload_inc >= length_hold) begin
        header_count_next = '0;
        res.status        = tfd_pkg::ST_COMPLETE;
        res.last          = 1'b1;
      end else begin
        res.status = tfd_pkg::ST_PAYLOAD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header_count  <= '0;
      type_hold     <= '0;
      flags_hold    <= '0;
      length_hold   <= '0;
      payload_count <= '0;
      error_hold    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (q_pop) begin
        header_count  <= header_count_next;
        type_hold     <= type_hold_next;
        flags_hold    <= flags_hold_next;
        length_hold   <= length_hold_next;
        payload_count <= payload_count_next;
        error_hold    <= error_hold_next;
        out_valid     <= 1'b1;
      end else if (out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_reg <= res;
    end
  end

  assign out.valid         = out_valid;
  assign out.status        = out_reg.status;
  assign out.payload_valid = out_reg.payload_valid;
  assign out.payload_byte  = out_reg.payload_byte;
  assign out.frame_code    = out_reg.frame_code;
  assign out.frame_flags   = out_reg.frame_flags;
  assign out.frame_length  = out_reg.frame_length;
  assign out.last          = out_reg.last;

  `TFD_ASSERT_ALWAYS(a_hdr_bound, clk, rst, header_count <= tfd_pkg::HDR_BYTES)
  `TFD_ASSERT_IMP(a_err_hdr, clk, rst, error_hold, header_count == tfd_pkg::HDR_BYTES)
  `TFD_ASSERT_IMP(a_last_done, clk, rst, out_valid && out_reg.last,
    out_reg.status == tfd_pkg::ST_COMPLETE)

endmodule
